[rtl/core/sca_pkg.sv]
// Shared constants, codes and types of the slab class allocator.
// Used by sca_ctrl, sca_dp and slab_class_allocator; no dependencies.
package sca_pkg;

    localparam int NUM_CLASSES      = 64;
    localparam int FREE_STACK_DEPTH = 256;
    localparam int ALIGN_BYTES      = 8;
    localparam int ADDR_BITS        = 24;

    localparam int CLS_W      = $clog2(NUM_CLASSES);
    localparam int TOP_W      = $clog2(FREE_STACK_DEPTH + 1);
    localparam int SLOT_W     = $clog2(FREE_STACK_DEPTH);
    localparam int STK_AW     = CLS_W + SLOT_W;
    localparam int STK_DEPTH  = NUM_CLASSES * FREE_STACK_DEPTH;

    localparam int CMD_W      = 2;
    localparam int SIZE_W     = 21;
    localparam int GROW_W     = 11;
    localparam int LIMIT_W    = 25;
    localparam int FIXED_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int REQB_W     = 32;
    localparam int CFG_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int Q_FRAC     = 8;

    localparam int CHUNK_W    = SIZE_W + 1;
    localparam int PER_W      = SIZE_W;
    localparam int SLABS_W    = 16;
    localparam int SIZE_REG_W = SIZE_W + GROW_W - Q_FRAC + 1;
    localparam int PROD_W     = SIZE_REG_W + PER_W;
    localparam int SUM_W      = CHUNK_W + PER_W + CLS_W + 1;
    localparam int ARENA_W    = ADDR_BITS + 1;
    localparam int DIV_STEPS  = SIZE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [ARENA_W-1:0] ARENA_CAP = ARENA_W'(1) << ADDR_BITS;
    localparam logic [SLABS_W-1:0] SLABS_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_CLASS  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_MEM     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_STACK_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_UNFIT      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED = 3'd4;

    localparam logic [SIZE_W-1:0]  RST_BASE  = 21'd48;
    localparam logic [GROW_W-1:0]  RST_GROW  = 11'd320;
    localparam logic [SIZE_W-1:0]  RST_MAX   = 21'd1048576;
    localparam logic [LIMIT_W-1:0] RST_LIMIT = '0;
    localparam logic [FIXED_W-1:0] RST_FIXED = '0;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_B_INIT,
        OP_B_MUL,
        OP_B_ALIGN,
        OP_B_DIV,
        OP_B_WRITE,
        OP_B_NEXT,
        OP_B_LAST,
        OP_B_FIN,
        OP_ACCEPT,
        OP_L_READ,
        OP_L_STEP,
        OP_L_FAIL,
        OP_L_FOUND,
        OP_S_READ,
        OP_BAD,
        OP_A_PUSH,
        OP_A_FULL,
        OP_A_POP,
        OP_A_POPD,
        OP_A_PAGE,
        OP_A_MUL,
        OP_A_SLAB,
        OP_A_OOM,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk;
        logic [PER_W-1:0]   per;
    } class_entry_t;

    typedef struct packed {
        logic                 open;
        logic [ADDR_BITS-1:0] next;
        logic [PER_W-1:0]     left;
        logic [TOP_W-1:0]     top;
        logic [SLABS_W-1:0]   slabs;
        logic [REQB_W-1:0]    req;
    } class_state_t;

    typedef struct packed {
        logic             cfg_hit;
        logic [CMD_W-1:0] cmd;
        logic             size_zero;
        logic             bad_class;
        logic             more_classes;
        logic             use_fixed;
        logic             div_last;
        logic             lk_gt;
        logic             lk_last;
        logic             top_nz;
        logic             page_open;
        logic             slab_ok;
        logic             stack_full;
        logic             out_free;
    } dp_status_t;

    typedef struct packed {
        op_t  op;
        logic idle;
    } ctrl_cmd_t;

endpackage

[rtl/core/slab_class_allocator.sv]
// Slab class allocator: one word in, one result word out per command.
// One word at a time; input stalls while a command is in progress or the class
// table is built (a 21-step divider for each class but the last, skipped when
// chunks per slab is fixed). The build runs after reset and every register write.
// Uses sca_pkg, sca_ctrl, sca_dp.
module slab_class_allocator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [sca_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sca_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [sca_pkg::CMD_W-1:0]            command,
    input  logic [sca_pkg::SIZE_W-1:0]           request_size,
    input  logic [sca_pkg::CLS_W-1:0]            class_id,
    input  logic [sca_pkg::ADDR_BITS-1:0]        free_address,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [sca_pkg::STATUS_W-1:0]         status,
    output logic [sca_pkg::ADDR_BITS-1:0]        chunk_address,
    output logic [sca_pkg::CLS_W-1:0]            found_class,
    output logic [sca_pkg::REQB_W-1:0]           class_bytes_in_use
);

    sca_pkg::ctrl_cmd_t  cmd;
    sca_pkg::dp_status_t stat;

    sca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    sca_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .command            (command),
        .request_size       (request_size),
        .class_id           (class_id),
        .free_address       (free_address),
        .out_stall          (out_stall),
        .out_valid          (out_valid),
        .status             (status),
        .chunk_address      (chunk_address),
        .found_class        (found_class),
        .class_bytes_in_use (class_bytes_in_use)
    );

    assign in_stall = !cmd.idle;

endmodule

[rtl/core/sca_ram.sv]
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/sca_ctrl.sv]
// Sequencer of the slab class allocator: class table build, lookup walk,
// allocate and free steps. Uses sca_pkg; drives the datapath sca_dp.
module sca_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  sca_pkg::dp_status_t stat,
    output sca_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [17:0] {
        S_BINIT  = 18'h00001,
        S_BMUL   = 18'h00002,
        S_BTEST  = 18'h00004,
        S_BALIGN = 18'h00008,
        S_BDIV   = 18'h00010,
        S_BWRITE = 18'h00020,
        S_BNEXT  = 18'h00040,
        S_BLAST  = 18'h00080,
        S_BFIN   = 18'h00100,
        S_IDLE   = 18'h00200,
        S_DISP   = 18'h00400,
        S_LREAD  = 18'h00800,
        S_LCMP   = 18'h01000,
        S_LDONE  = 18'h02000,
        S_AEVAL  = 18'h04000,
        S_APOPD  = 18'h08000,
        S_ASLAB  = 18'h10000,
        S_EMIT   = 18'h20000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    sca_pkg::op_t  op;

    always_comb
    begin
        state_next = state_reg;
        op         = sca_pkg::OP_NONE;
        case (state_reg)
            S_BINIT:
            begin
                op         = sca_pkg::OP_B_INIT;
                state_next = S_BMUL;
            end
            S_BMUL:
            begin
                op         = sca_pkg::OP_B_MUL;
                state_next = S_BTEST;
            end
            S_BTEST:
            begin
                state_next = stat.more_classes ? S_BALIGN : S_BLAST;
            end
            S_BALIGN:
            begin
                op         = sca_pkg::OP_B_ALIGN;
                state_next = stat.use_fixed ? S_BWRITE : S_BDIV;
            end
            S_BDIV:
            begin
                op = sca_pkg::OP_B_DIV;
                if (stat.div_last)
                begin
                    state_next = S_BWRITE;
                end
            end
            S_BWRITE:
            begin
                op         = sca_pkg::OP_B_WRITE;
                state_next = S_BNEXT;
            end
            S_BNEXT:
            begin
                op         = sca_pkg::OP_B_NEXT;
                state_next = S_BMUL;
            end
            S_BLAST:
            begin
                op         = sca_pkg::OP_B_LAST;
                state_next = S_BFIN;
            end
            S_BFIN:
            begin
                op         = sca_pkg::OP_B_FIN;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = sca_pkg::OP_ACCEPT;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_EMIT;
                if (stat.cmd == sca_pkg::CMD_LOOKUP)
                begin
                    if (stat.size_zero)
                    begin
                        op = sca_pkg::OP_L_FAIL;
                    end
                    else
                    begin
                        op         = sca_pkg::OP_L_READ;
                        state_next = S_LCMP;
                    end
                end
                else if (stat.cmd == sca_pkg::CMD_ALLOC || stat.cmd == sca_pkg::CMD_FREE)
                begin
                    if (stat.bad_class)
                    begin
                        op = sca_pkg::OP_BAD;
                    end
                    else
                    begin
                        op         = sca_pkg::OP_S_READ;
                        state_next = S_AEVAL;
                    end
                end
            end
            S_LREAD:
            begin
                op         = sca_pkg::OP_L_READ;
                state_next = S_LCMP;
            end
            S_LCMP:
            begin
                if (stat.lk_gt && stat.lk_last)
                begin
                    op         = sca_pkg::OP_L_FAIL;
                    state_next = S_EMIT;
                end
                else if (stat.lk_gt)
                begin
                    op         = sca_pkg::OP_L_STEP;
                    state_next = S_LREAD;
                end
                else
                begin
                    op         = sca_pkg::OP_S_READ;
                    state_next = S_LDONE;
                end
            end
            S_LDONE:
            begin
                op         = sca_pkg::OP_L_FOUND;
                state_next = S_EMIT;
            end
            S_AEVAL:
            begin
                state_next = S_EMIT;
                if (stat.cmd == sca_pkg::CMD_FREE)
                begin
                    op = stat.stack_full ? sca_pkg::OP_A_FULL : sca_pkg::OP_A_PUSH;
                end
                else if (stat.top_nz)
                begin
                    op         = sca_pkg::OP_A_POP;
                    state_next = S_APOPD;
                end
                else if (stat.page_open)
                begin
                    op = sca_pkg::OP_A_PAGE;
                end
                else
                begin
                    op         = sca_pkg::OP_A_MUL;
                    state_next = S_ASLAB;
                end
            end
            S_APOPD:
            begin
                op         = sca_pkg::OP_A_POPD;
                state_next = S_EMIT;
            end
            S_ASLAB:
            begin
                op         = stat.slab_ok ? sca_pkg::OP_A_SLAB : sca_pkg::OP_A_OOM;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    op         = sca_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_BINIT;
            end
        endcase
        if (stat.cfg_hit)
        begin
            state_next = S_BINIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BINIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.op   = op;
    assign cmd.idle = (state_reg == S_IDLE);

endmodule

[rtl/core/sca_dp.sv]
// Datapath of the slab class allocator: registers, class table, per-class
// state, free stacks, shared multiplier and divider. Uses sca_pkg, sca_ram.
module sca_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sca_pkg::ctrl_cmd_t                   cmd,
    output sca_pkg::dp_status_t                  stat,
    input  logic                                 cfg_write,
    input  logic [sca_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sca_pkg::CFG_W-1:0]            cfg_data,
    input  logic [sca_pkg::CMD_W-1:0]            command,
    input  logic [sca_pkg::SIZE_W-1:0]           request_size,
    input  logic [sca_pkg::CLS_W-1:0]            class_id,
    input  logic [sca_pkg::ADDR_BITS-1:0]        free_address,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic [sca_pkg::STATUS_W-1:0]         status,
    output logic [sca_pkg::ADDR_BITS-1:0]        chunk_address,
    output logic [sca_pkg::CLS_W-1:0]            found_class,
    output logic [sca_pkg::REQB_W-1:0]           class_bytes_in_use
);

    logic [sca_pkg::SIZE_W-1:0]     base_reg;
    logic [sca_pkg::GROW_W-1:0]     grow_reg;
    logic [sca_pkg::SIZE_W-1:0]     max_reg;
    logic [sca_pkg::LIMIT_W-1:0]    mem_limit_reg;
    logic [sca_pkg::FIXED_W-1:0]    fixed_reg;

    logic [sca_pkg::CMD_W-1:0]      cmd_reg;
    logic [sca_pkg::SIZE_W-1:0]     size_in_reg;
    logic [sca_pkg::CLS_W-1:0]      id_reg;
    logic [sca_pkg::ADDR_BITS-1:0]  addr_in_reg;
    logic [sca_pkg::CLS_W-1:0]      res_reg;

    logic [sca_pkg::CLS_W-1:0]      i_reg;
    logic [sca_pkg::CLS_W-1:0]      largest_reg;
    logic [sca_pkg::SIZE_REG_W-1:0] size_reg;
    logic [sca_pkg::CHUNK_W-1:0]    chunk_reg;
    logic [sca_pkg::SUM_W-1:0]      sum_reg;
    logic [sca_pkg::SUM_W-1:0]      limit_reg;
    logic [sca_pkg::ARENA_W-1:0]    arena_next_reg;
    logic [sca_pkg::ARENA_W-1:0]    arena_left_reg;
    logic [sca_pkg::ARENA_W-1:0]    carved_reg;
    logic [sca_pkg::PROD_W-1:0]     prod_reg;
    logic [sca_pkg::CHUNK_W-1:0]    rem_reg;
    logic [sca_pkg::PER_W-1:0]      quot_reg;
    logic [sca_pkg::DIV_CNT_W-1:0]  div_cnt_reg;
    logic [sca_pkg::NUM_CLASSES-1:0] valid_reg;

    logic [sca_pkg::STATUS_W-1:0]   r_status_reg;
    logic [sca_pkg::ADDR_BITS-1:0]  r_chunk_reg;
    logic [sca_pkg::CLS_W-1:0]      r_found_reg;
    logic [sca_pkg::REQB_W-1:0]     r_inuse_reg;
    logic                           out_valid_reg;
    logic [sca_pkg::STATUS_W-1:0]   o_status_reg;
    logic [sca_pkg::ADDR_BITS-1:0]  o_chunk_reg;
    logic [sca_pkg::CLS_W-1:0]      o_found_reg;
    logic [sca_pkg::REQB_W-1:0]     o_inuse_reg;

    logic [sca_pkg::CLS_W-1:0]      cls_addr;
    sca_pkg::class_entry_t          tbl_q;
    sca_pkg::class_entry_t          tbl_wdata;
    logic [$bits(sca_pkg::class_entry_t)-1:0] tbl_q_raw;
    logic                           tbl_we;
    logic [$bits(sca_pkg::class_state_t)-1:0] st_q_raw;
    sca_pkg::class_state_t          st_cur;
    sca_pkg::class_state_t          st_new;
    logic                           st_we;
    logic [sca_pkg::ADDR_BITS-1:0]  stk_q;
    logic [sca_pkg::TOP_W-1:0]      top_dec;
    logic [sca_pkg::STK_AW-1:0]     stk_waddr;
    logic [sca_pkg::STK_AW-1:0]     stk_raddr;

    logic [sca_pkg::SIZE_REG_W-1:0] mul_a;
    logic [sca_pkg::PER_W-1:0]      mul_b;
    logic [sca_pkg::PROD_W-1:0]     prod_full;
    logic [sca_pkg::PER_W-1:0]      per_val;
    logic [sca_pkg::PER_W-1:0]      per_last;
    logic [sca_pkg::SIZE_REG_W:0]   align_sum;
    logic [sca_pkg::SIZE_REG_W:0]   align_val;
    logic [sca_pkg::CHUNK_W:0]      rem_sh;
    logic [sca_pkg::SUM_W-1:0]      total;
    logic [sca_pkg::SUM_W-1:0]      limit_next;
    logic [sca_pkg::ARENA_W:0]      step_raw;
    logic [sca_pkg::ARENA_W:0]      step;
    logic [sca_pkg::PROD_W:0]       carve_sum;
    logic [sca_pkg::PER_W-1:0]      per_dec;
    logic [sca_pkg::PER_W-1:0]      left_dec;

    assign cls_addr = (cmd_reg == sca_pkg::CMD_LOOKUP) ? res_reg : id_reg;
    assign tbl_q    = sca_pkg::class_entry_t'(tbl_q_raw);
    assign st_cur   = valid_reg[cls_addr] ? sca_pkg::class_state_t'(st_q_raw) : '0;
    assign top_dec  = st_cur.top - sca_pkg::TOP_W'(1);
    assign per_dec  = tbl_q.per - sca_pkg::PER_W'(1);
    assign left_dec = st_cur.left - sca_pkg::PER_W'(1);

    assign per_val  = (fixed_reg != '0) ? sca_pkg::PER_W'(fixed_reg) : quot_reg;
    assign per_last = (fixed_reg != '0) ? sca_pkg::PER_W'(fixed_reg) : sca_pkg::PER_W'(1);

    always_comb
    begin
        case (cmd.op)
            sca_pkg::OP_B_MUL:
            begin
                mul_a = size_reg;
                mul_b = sca_pkg::PER_W'(grow_reg);
            end
            sca_pkg::OP_B_WRITE:
            begin
                mul_a = sca_pkg::SIZE_REG_W'(chunk_reg);
                mul_b = per_val;
            end
            sca_pkg::OP_B_NEXT:
            begin
                mul_a = sca_pkg::SIZE_REG_W'(chunk_reg);
                mul_b = sca_pkg::PER_W'(grow_reg);
            end
            sca_pkg::OP_B_LAST:
            begin
                mul_a = sca_pkg::SIZE_REG_W'(max_reg);
                mul_b = per_last;
            end
            default:
            begin
                mul_a = sca_pkg::SIZE_REG_W'(tbl_q.chunk);
                mul_b = tbl_q.per;
            end
        endcase
    end

    assign prod_full = sca_pkg::PROD_W'(mul_a) * sca_pkg::PROD_W'(mul_b);

    assign align_sum = (sca_pkg::SIZE_REG_W + 1)'(size_reg)
                     + (sca_pkg::SIZE_REG_W + 1)'(sca_pkg::ALIGN_BYTES - 1);
    always_comb
    begin
        align_val = align_sum & ~((sca_pkg::SIZE_REG_W + 1)'(sca_pkg::ALIGN_BYTES - 1));
        if (align_val < (sca_pkg::SIZE_REG_W + 1)'(sca_pkg::ALIGN_BYTES))
        begin
            align_val = (sca_pkg::SIZE_REG_W + 1)'(sca_pkg::ALIGN_BYTES);
        end
    end

    assign rem_sh = {rem_reg, quot_reg[sca_pkg::PER_W-1]};

    assign total      = sum_reg + prod_reg[sca_pkg::SUM_W-1:0];
    assign limit_next = (mem_limit_reg != '0) ? sca_pkg::SUM_W'(mem_limit_reg) : total;

    assign step_raw = (sca_pkg::ARENA_W + 1)'(prod_reg[sca_pkg::ARENA_W-1:0])
                    + (sca_pkg::ARENA_W + 1)'(sca_pkg::ALIGN_BYTES - 1);
    assign step     = step_raw & ~((sca_pkg::ARENA_W + 1)'(sca_pkg::ALIGN_BYTES - 1));
    assign carve_sum = (sca_pkg::PROD_W + 1)'(carved_reg) + (sca_pkg::PROD_W + 1)'(prod_reg);

    always_comb
    begin
        st_new = st_cur;
        st_we  = 1'b0;
        case (cmd.op)
            sca_pkg::OP_A_PUSH:
            begin
                st_we      = 1'b1;
                st_new.top = st_cur.top + sca_pkg::TOP_W'(1);
                st_new.req = st_cur.req - sca_pkg::REQB_W'(size_in_reg);
            end
            sca_pkg::OP_A_POP:
            begin
                st_we      = 1'b1;
                st_new.top = top_dec;
                st_new.req = st_cur.req + sca_pkg::REQB_W'(size_in_reg);
            end
            sca_pkg::OP_A_PAGE:
            begin
                st_we       = 1'b1;
                st_new.left = left_dec;
                if (left_dec != '0)
                begin
                    st_new.next = st_cur.next + sca_pkg::ADDR_BITS'(tbl_q.chunk);
                end
                else
                begin
                    st_new.open = 1'b0;
                end
                st_new.req = st_cur.req + sca_pkg::REQB_W'(size_in_reg);
            end
            sca_pkg::OP_A_SLAB:
            begin
                st_we       = 1'b1;
                st_new.left = per_dec;
                st_new.open = (per_dec != '0);
                st_new.next = arena_next_reg[sca_pkg::ADDR_BITS-1:0]
                            + sca_pkg::ADDR_BITS'(tbl_q.chunk);
                if (st_cur.slabs != sca_pkg::SLABS_MAX)
                begin
                    st_new.slabs = st_cur.slabs + sca_pkg::SLABS_W'(1);
                end
                st_new.req = st_cur.req + sca_pkg::REQB_W'(size_in_reg);
            end
            default:
            begin
                st_we = 1'b0;
            end
        endcase
    end

    assign tbl_we    = (cmd.op == sca_pkg::OP_B_WRITE) || (cmd.op == sca_pkg::OP_B_LAST);
    assign tbl_wdata = (cmd.op == sca_pkg::OP_B_LAST)
                     ? '{chunk: sca_pkg::CHUNK_W'(max_reg), per: per_last}
                     : '{chunk: chunk_reg, per: per_val};
    assign stk_waddr = {id_reg, st_cur.top[sca_pkg::SLOT_W-1:0]};
    assign stk_raddr = {id_reg, top_dec[sca_pkg::SLOT_W-1:0]};

    sca_ram #(
        .WIDTH ($bits(sca_pkg::class_entry_t)),
        .DEPTH (sca_pkg::NUM_CLASSES)
    ) u_tbl_ram (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (i_reg),
        .wr_data (tbl_wdata),
        .rd_en   ((cmd.op == sca_pkg::OP_L_READ) || (cmd.op == sca_pkg::OP_S_READ)),
        .rd_addr (cls_addr),
        .rd_data (tbl_q_raw)
    );

    sca_ram #(
        .WIDTH ($bits(sca_pkg::class_state_t)),
        .DEPTH (sca_pkg::NUM_CLASSES)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (id_reg),
        .wr_data (st_new),
        .rd_en   (cmd.op == sca_pkg::OP_S_READ),
        .rd_addr (cls_addr),
        .rd_data (st_q_raw)
    );

    sca_ram #(
        .WIDTH (sca_pkg::ADDR_BITS),
        .DEPTH (sca_pkg::STK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (cmd.op == sca_pkg::OP_A_PUSH),
        .wr_addr (stk_waddr),
        .wr_data (addr_in_reg),
        .rd_en   (cmd.op == sca_pkg::OP_A_POP),
        .rd_addr (stk_raddr),
        .rd_data (stk_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= sca_pkg::RST_BASE;
            grow_reg      <= sca_pkg::RST_GROW;
            max_reg       <= sca_pkg::RST_MAX;
            mem_limit_reg <= sca_pkg::RST_LIMIT;
            fixed_reg     <= sca_pkg::RST_FIXED;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    sca_pkg::CFG_BASE:  base_reg      <= cfg_data[sca_pkg::SIZE_W-1:0];
                    sca_pkg::CFG_GROW:  grow_reg      <= cfg_data[sca_pkg::GROW_W-1:0];
                    sca_pkg::CFG_MAX:   max_reg       <= cfg_data[sca_pkg::SIZE_W-1:0];
                    sca_pkg::CFG_LIMIT: mem_limit_reg <= cfg_data[sca_pkg::LIMIT_W-1:0];
                    sca_pkg::CFG_FIXED: fixed_reg     <= cfg_data[sca_pkg::FIXED_W-1:0];
                    default:            base_reg      <= base_reg;
                endcase
            end
            if (cmd.op == sca_pkg::OP_B_INIT)
            begin
                valid_reg <= '0;
            end
            else if (st_we)
            begin
                valid_reg[id_reg] <= 1'b1;
            end
            if (cmd.op == sca_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sca_pkg::OP_B_INIT:
            begin
                i_reg          <= sca_pkg::CLS_W'(1);
                size_reg       <= sca_pkg::SIZE_REG_W'(base_reg);
                sum_reg        <= '0;
                arena_next_reg <= '0;
                carved_reg     <= '0;
            end
            sca_pkg::OP_B_MUL:
            begin
                prod_reg <= prod_full;
            end
            sca_pkg::OP_B_ALIGN:
            begin
                chunk_reg   <= align_val[sca_pkg::CHUNK_W-1:0];
                rem_reg     <= '0;
                quot_reg    <= max_reg;
                div_cnt_reg <= sca_pkg::DIV_CNT_W'(sca_pkg::DIV_STEPS);
            end
            sca_pkg::OP_B_DIV:
            begin
                div_cnt_reg <= div_cnt_reg - sca_pkg::DIV_CNT_W'(1);
                if (rem_sh >= (sca_pkg::CHUNK_W + 1)'(chunk_reg))
                begin
                    rem_reg  <= sca_pkg::CHUNK_W'(rem_sh - (sca_pkg::CHUNK_W + 1)'(chunk_reg));
                    quot_reg <= {quot_reg[sca_pkg::PER_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[sca_pkg::CHUNK_W-1:0];
                    quot_reg <= {quot_reg[sca_pkg::PER_W-2:0], 1'b0};
                end
            end
            sca_pkg::OP_B_WRITE:
            begin
                prod_reg <= prod_full;
            end
            sca_pkg::OP_B_NEXT:
            begin
                sum_reg  <= total;
                size_reg <= prod_full[sca_pkg::Q_FRAC +: sca_pkg::SIZE_REG_W];
                i_reg    <= i_reg + sca_pkg::CLS_W'(1);
            end
            sca_pkg::OP_B_LAST:
            begin
                largest_reg <= i_reg;
                prod_reg    <= prod_full;
            end
            sca_pkg::OP_B_FIN:
            begin
                limit_reg <= limit_next;
                if (limit_next < sca_pkg::SUM_W'(sca_pkg::ARENA_CAP))
                begin
                    arena_left_reg <= limit_next[sca_pkg::ARENA_W-1:0];
                end
                else
                begin
                    arena_left_reg <= sca_pkg::ARENA_CAP;
                end
            end
            sca_pkg::OP_ACCEPT:
            begin
                cmd_reg      <= command;
                size_in_reg  <= request_size;
                id_reg       <= class_id;
                addr_in_reg  <= free_address;
                res_reg      <= sca_pkg::CLS_W'(1);
                r_status_reg <= sca_pkg::STAT_OK;
                r_chunk_reg  <= '0;
                r_found_reg  <= '0;
                r_inuse_reg  <= '0;
            end
            sca_pkg::OP_L_STEP:
            begin
                res_reg <= res_reg + sca_pkg::CLS_W'(1);
            end
            sca_pkg::OP_L_FAIL:
            begin
                r_status_reg <= sca_pkg::STAT_UNFIT;
            end
            sca_pkg::OP_L_FOUND:
            begin
                r_found_reg <= res_reg;
                r_inuse_reg <= st_cur.req;
            end
            sca_pkg::OP_BAD:
            begin
                r_status_reg <= sca_pkg::STAT_BAD_CLASS;
            end
            sca_pkg::OP_A_PUSH:
            begin
                r_inuse_reg <= st_new.req;
            end
            sca_pkg::OP_A_FULL:
            begin
                r_status_reg <= sca_pkg::STAT_STACK_FULL;
                r_inuse_reg  <= st_cur.req;
            end
            sca_pkg::OP_A_POP:
            begin
                r_inuse_reg <= st_new.req;
            end
            sca_pkg::OP_A_POPD:
            begin
                r_chunk_reg <= stk_q;
            end
            sca_pkg::OP_A_PAGE:
            begin
                r_chunk_reg <= st_cur.next;
                r_inuse_reg <= st_new.req;
            end
            sca_pkg::OP_A_MUL:
            begin
                prod_reg <= prod_full;
            end
            sca_pkg::OP_A_SLAB:
            begin
                r_chunk_reg    <= arena_next_reg[sca_pkg::ADDR_BITS-1:0];
                r_inuse_reg    <= st_new.req;
                carved_reg     <= carved_reg + prod_reg[sca_pkg::ARENA_W-1:0];
                arena_next_reg <= arena_next_reg + step[sca_pkg::ARENA_W-1:0];
                if (step < (sca_pkg::ARENA_W + 1)'(arena_left_reg))
                begin
                    arena_left_reg <= arena_left_reg - step[sca_pkg::ARENA_W-1:0];
                end
                else
                begin
                    arena_left_reg <= '0;
                end
            end
            sca_pkg::OP_A_OOM:
            begin
                r_status_reg <= sca_pkg::STAT_NO_MEM;
                r_inuse_reg  <= st_cur.req;
            end
            sca_pkg::OP_EMIT:
            begin
                o_status_reg <= r_status_reg;
                o_chunk_reg  <= r_chunk_reg;
                o_found_reg  <= r_found_reg;
                o_inuse_reg  <= r_inuse_reg;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign stat.cfg_hit      = cfg_write && (cfg_index <= sca_pkg::CFG_FIXED);
    assign stat.cmd          = cmd_reg;
    assign stat.size_zero    = (size_in_reg == '0);
    assign stat.bad_class    = (id_reg == '0) || (id_reg > largest_reg);
    assign stat.more_classes = (i_reg < sca_pkg::CLS_W'(sca_pkg::NUM_CLASSES - 1))
                            && (prod_reg <= sca_pkg::PROD_W'({max_reg, {sca_pkg::Q_FRAC{1'b0}}}));
    assign stat.use_fixed    = (fixed_reg != '0);
    assign stat.div_last     = (div_cnt_reg == sca_pkg::DIV_CNT_W'(1));
    assign stat.lk_gt        = (sca_pkg::CHUNK_W'(size_in_reg) > tbl_q.chunk);
    assign stat.lk_last      = (res_reg >= largest_reg);
    assign stat.top_nz       = (st_cur.top != '0);
    assign stat.page_open    = st_cur.open;
    assign stat.stack_full   = (st_cur.top >= sca_pkg::TOP_W'(sca_pkg::FREE_STACK_DEPTH));
    assign stat.slab_ok      = (prod_reg != '0) && (tbl_q.per != '0)
                            && !((limit_reg != '0)
                                 && (carve_sum > (sca_pkg::PROD_W + 1)'(limit_reg))
                                 && (st_cur.slabs != '0))
                            && (prod_reg <= sca_pkg::PROD_W'(arena_left_reg));
    assign stat.out_free     = !out_valid_reg || !out_stall;

    assign out_valid          = out_valid_reg;
    assign status             = o_status_reg;
    assign chunk_address      = o_chunk_reg;
    assign found_class        = o_found_reg;
    assign class_bytes_in_use = o_inuse_reg;

    a_build_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == sca_pkg::OP_B_INIT |=> valid_reg == '0)
        else $error("valid bits not cleared by build");

    a_arena_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == sca_pkg::OP_A_SLAB |=> arena_left_reg <= sca_pkg::ARENA_CAP)
        else $error("arena space beyond address range");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> st_new.top <= sca_pkg::TOP_W'(sca_pkg::FREE_STACK_DEPTH))
        else $error("free stack overrun");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == sca_pkg::OP_EMIT |-> (!out_valid_reg || !out_stall))
        else $error("result word overwritten while stalled");

endmodule
